@@ hw/rtl/lphm_pkg.sv @@
// Shared constants and types for the linear-probing hash map.
`default_nettype none
package lphm_pkg;

    // One-word FNV-1a hash constants.
    localparam logic [31:0] FNV_OFFSET = 32'h811c_9dc5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

    // Operation codes carried on the func field.
    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    // Write strobes from the sequencer to the slot table.
    typedef struct packed {
        logic key_wr;
        logic value_wr;
    } lphm_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/lphm_hash.sv @@
// Registered hash unit that maps a key to its home slot.
`default_nettype none
module lphm_hash
    import lphm_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  wire logic             clk,
    input  wire logic [31:0]      key,
    output logic      [IDX_W-1:0] home
);

    logic [31:0]      product;
    logic [IDX_W-1:0] home_reg;

    // The hash is taken modulo 2^32; the slot index is its low bits.
    assign product = (FNV_OFFSET ^ key) * FNV_PRIME;

    always_ff @(posedge clk)
    begin
        home_reg <= product[IDX_W-1:0];
    end

    assign home = home_reg;

endmodule
`default_nettype wire

@@ hw/rtl/lphm_table.sv @@
// Slot table: key memory with occupied flag and value memory, registered reads.
`default_nettype none
module lphm_table
    import lphm_pkg::*;
#(
    parameter  int SLOTS = 64,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  wire logic             clk,
    input  wire lphm_wr_t         wr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic             wr_occ,
    input  wire logic [31:0]      wr_key,
    input  wire logic [63:0]      wr_value,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic                  rd_occ,
    output logic      [31:0]      rd_key,
    output logic      [63:0]      rd_value
);

    // The occupied flag rides in the top bit of each key word.
    logic [32:0] key_mem [SLOTS];
    logic [63:0] value_mem [SLOTS];
    logic [32:0] key_rd_reg;
    logic [63:0] value_rd_reg;

    // Key memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.key_wr)
        begin
            key_mem[wr_addr] <= {wr_occ, wr_key};
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    // Value memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.value_wr)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        value_rd_reg <= value_mem[rd_addr];
    end

    assign rd_occ   = key_rd_reg[32];
    assign rd_key   = key_rd_reg[31:0];
    assign rd_value = value_rd_reg;

endmodule
`default_nettype wire

@@ hw/rtl/linear_probe_hash_map_unit.sv @@
// Top level: probe sequencer of the linear-probing hash map.
// Flow: an accepted request passes ST_HASH, ST_FIRST, the probe loop in ST_PROBE and
// ST_FINISH, which raises out_valid; the probe loop reads and compares one slot per cycle
// and probes from 1 to TABLE_SLOTS slots. Only one request is in work at a time.
// Reset: asynchronous; afterwards a clearing pass in ST_CLEAR marks every slot unused,
// and in_stall stays high until it is done.
`default_nettype none
module linear_probe_hash_map_unit
    import lphm_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [31:0] key,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic      [63:0] read_value
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_FIRST,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             func_reg, func_next;
    logic [31:0]      key_reg, key_next;
    logic [63:0]      value_reg, value_next;
    logic             res_ok_reg, res_ok_next;
    logic [63:0]      res_value_reg, res_value_next;
    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    logic [63:0]      read_value_reg, read_value_next;

    logic [IDX_W-1:0] home;
    lphm_wr_t         wr;
    logic             wr_occ;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_occ;
    logic [31:0]      rd_key;
    logic [63:0]      rd_value;
    logic             key_match;

    // Home slot of the held key.
    lphm_hash #(
        .IDX_W (IDX_W)
    ) u_hash (
        .clk  (clk),
        .key  (key_reg),
        .home (home)
    );

    // Key and value storage.
    lphm_table #(
        .SLOTS (TABLE_SLOTS)
    ) u_table (
        .clk      (clk),
        .wr       (wr),
        .wr_addr  (slot_reg),
        .wr_occ   (wr_occ),
        .wr_key   (key_reg),
        .wr_value (value_reg),
        .rd_addr  (rd_addr),
        .rd_occ   (rd_occ),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // The first read goes to the home slot; each probe cycle reads one slot ahead.
    assign rd_addr   = (state_reg == ST_PROBE) ? slot_reg + IDX_W'(1) : home;
    assign wr_occ    = (state_reg != ST_CLEAR);
    assign key_match = (rd_key == key_reg);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        res_ok_next     = res_ok_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        ok_next         = ok_reg;
        read_value_next = read_value_reg;
        wr              = '0;

        // A waiting result leaves once the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr.key_wr = 1'b1;
                slot_next = slot_reg + IDX_W'(1);
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    key_next   = key;
                    value_next = value;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                slot_next  = home;
                count_next = '0;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                res_value_next = '0;
                if (func_reg == FUNC_SET && (!rd_occ || key_match))
                begin
                    // Free slot or same key: store here.
                    wr.key_wr      = 1'b1;
                    wr.value_wr    = 1'b1;
                    res_ok_next    = 1'b1;
                    state_next     = ST_FINISH;
                end
                else if (func_reg == FUNC_GET && !rd_occ)
                begin
                    // An unused slot ends the chain: not found.
                    res_ok_next    = 1'b0;
                    state_next     = ST_FINISH;
                end
                else if (func_reg == FUNC_GET && key_match)
                begin
                    res_ok_next    = 1'b1;
                    res_value_next = rd_value;
                    state_next     = ST_FINISH;
                end
                else if (count_reg == LAST_SLOT)
                begin
                    // Every slot has been probed once.
                    res_ok_next    = 1'b0;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    slot_next  = slot_reg + IDX_W'(1);
                    count_next = count_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    ok_next         = res_ok_reg;
                    read_value_next = res_value_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            slot_reg       <= '0;
            count_reg      <= '0;
            func_reg       <= FUNC_SET;
            key_reg        <= '0;
            value_reg      <= '0;
            res_ok_reg     <= 1'b0;
            res_value_reg  <= '0;
            out_valid_reg  <= 1'b0;
            ok_reg         <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            func_reg       <= func_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            res_ok_reg     <= res_ok_next;
            res_value_reg  <= res_value_next;
            out_valid_reg  <= out_valid_next;
            ok_reg         <= ok_next;
            read_value_reg <= read_value_next;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign read_value = read_value_reg;

endmodule
`default_nettype wire

@@ hw/rtl/lphm_checker.sv @@
// Port-level checker for the hash map top level, with its bind statement.
`default_nettype none
module lphm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        ok,
    input wire logic [63:0] read_value
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(read_value))
        else $error("stalled result changed");

    // A miss or a failed store always reports a zero value.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> read_value == 64'd0)
        else $error("nonzero value with ok low");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in work");

    // The clearing pass after reset holds off requests.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall && !out_valid)
        else $error("request taken during clearing pass");

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ok         (ok),
    .read_value (read_value)
);
`default_nettype wire
